// ===== rtl/core/rfs_pkg.sv =====
// Package for the record field splitter: sizes, character codes and the
// request/result and status types shared by the splitter modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rfs_pkg;

    localparam int MAX_FIELDS    = 64;
    localparam int SEP_MAX_BYTES = 8;
    localparam int POSITION_BITS = 16;

    localparam int SEP_LEN_BITS  = 4;
    localparam int SEP_BITS      = 64;
    localparam int COUNT_BITS    = 7;
    localparam int NUMBER_BITS   = 6;
    localparam int RECORD_BITS   = 32;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] TAB_CHAR   = 8'h09;
    localparam logic [7:0] CR_CHAR    = 8'h0D;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    localparam logic REG_SEP_LENGTH = 1'b0;
    localparam logic REG_SEP_BYTES  = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic                     field_valid;
        logic [NUMBER_BITS-1:0]   field_number;
        logic [POSITION_BITS-1:0] field_start;
        logic [POSITION_BITS-1:0] field_length;
        logic                     record_end;
        logic [COUNT_BITS-1:0]    record_fields;
        logic [RECORD_BITS-1:0]   record_number;
    } out_item_t;

    // Separator decode handed from the matcher to the top level
    typedef struct packed {
        logic                    ws_mode;
        logic [SEP_LEN_BITS-1:0] sep_n;
        logic                    tail_match;
    } sep_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/rfs_sep_match.sv =====
// Separator decode and window compare for the record field splitter.
// Depends on rfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfs_sep_match
    import rfs_pkg::*;
(
    input  wire logic [SEP_LEN_BITS-1:0] sep_length,
    input  wire logic [SEP_BITS-1:0]     sep_bytes,
    input  wire logic [SEP_BITS-1:0]     window,
    output sep_status_t                  status
);

    logic [SEP_LEN_BITS-1:0] sep_n;
    logic [SEP_MAX_BYTES:0]  match_by_len;

    always_comb
    begin
        if (sep_length > SEP_LEN_BITS'(SEP_MAX_BYTES))
            sep_n = SEP_LEN_BITS'(SEP_MAX_BYTES);
        else
            sep_n = sep_length;
    end

    // Newest byte sits in the low byte of the window; it must equal the
    // last separator byte.
    always_comb
    begin
        logic all_eq;
        match_by_len[0] = 1'b0;
        for (int k = 1; k <= SEP_MAX_BYTES; k++)
        begin
            all_eq = 1'b1;
            for (int j = 0; j < k; j++)
            begin
                if (window[8*j +: 8] != sep_bytes[8*(k-1-j) +: 8])
                    all_eq = 1'b0;
            end
            match_by_len[k] = all_eq;
        end
    end

    always_comb
    begin
        status.sep_n      = sep_n;
        status.ws_mode    = (sep_n == '0) ||
                            (sep_n == SEP_LEN_BITS'(1) && sep_bytes[7:0] == SPACE_CHAR);
        status.tail_match = match_by_len[sep_n];
    end

endmodule

`default_nettype wire

// ===== rtl/core/record_field_splitter.sv =====
// Record field splitter: takes one record byte per request and reports
// the first 64 closed fields of a record (number, start offset, length),
// plus a summary at the end of each record. A request is taken every
// cycle while the result register is free or being emptied in the same
// cycle, so the block runs at one byte per clock. Separator compare, mode
// decode and counters settle in the request's cycle; results register next.
// Depends on rfs_pkg and rfs_sep_match.
`timescale 1ns / 1ps
`default_nettype none

module record_field_splitter
    import rfs_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire in_item_t                in_data,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output out_item_t                    out_data,
    input  wire logic                    cfg_write,
    input  wire logic                    cfg_index,
    input  wire logic [SEP_BITS-1:0]     cfg_data
);

    localparam logic [POSITION_BITS-1:0] POS_LIMIT = '1;

    logic [SEP_LEN_BITS-1:0]  sep_length_reg;
    logic [SEP_BITS-1:0]      sep_bytes_reg;
    logic [SEP_BITS-1:0]      recent_reg, recent_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic                     inside_reg, inside_next;
    logic [COUNT_BITS-1:0]    found_reg, found_next;
    logic [RECORD_BITS-1:0]   records_reg, records_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_data_reg, out_data_next;

    logic                     accept;
    logic                     has_result;
    logic                     blank;
    logic                     fits;
    logic                     room;
    sep_status_t              sep_st;

    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign recent_next = {recent_reg[SEP_BITS-9:0], in_data.data_byte};

    rfs_sep_match u_match (
        .sep_length (sep_length_reg),
        .sep_bytes  (sep_bytes_reg),
        .window     (recent_next),
        .status     (sep_st)
    );

    assign blank = (in_data.data_byte == SPACE_CHAR) ||
                   (in_data.data_byte >= TAB_CHAR && in_data.data_byte <= CR_CHAR);
    // Separator must not reach back before the open field's start
    assign fits  = ({1'b0, pos_reg} + (POSITION_BITS+1)'(1)) >=
                   ({1'b0, start_reg} + (POSITION_BITS+1)'(sep_st.sep_n));
    assign room  = found_reg < COUNT_BITS'(MAX_FIELDS);

    always_comb
    begin
        logic [POSITION_BITS-1:0] len;
        len           = '0;
        has_result    = 1'b0;
        out_data_next = '0;
        pos_next      = pos_reg;
        start_next    = start_reg;
        inside_next   = inside_reg;
        found_next    = found_reg;
        records_next  = records_reg;

        if (in_data.func == FUNC_DATA)
        begin
            if (pos_reg != POS_LIMIT)
            begin
                pos_next = pos_reg + POSITION_BITS'(1);
                if (sep_st.ws_mode)
                begin
                    if (blank && inside_reg)
                    begin
                        inside_next = 1'b0;
                        if (room)
                        begin
                            has_result                 = 1'b1;
                            out_data_next.field_valid  = 1'b1;
                            out_data_next.field_number = found_reg[NUMBER_BITS-1:0];
                            out_data_next.field_start  = start_reg;
                            out_data_next.field_length = pos_reg - start_reg;
                            found_next                 = found_reg + COUNT_BITS'(1);
                        end
                    end
                    else if (!blank && !inside_reg)
                    begin
                        inside_next = 1'b1;
                        start_next  = pos_reg;
                    end
                end
                else if (sep_st.tail_match && fits)
                begin
                    start_next = pos_reg + POSITION_BITS'(1);
                    if (room)
                    begin
                        has_result                 = 1'b1;
                        out_data_next.field_valid  = 1'b1;
                        out_data_next.field_number = found_reg[NUMBER_BITS-1:0];
                        out_data_next.field_start  = start_reg;
                        out_data_next.field_length = pos_reg + POSITION_BITS'(1)
                                                     - POSITION_BITS'(sep_st.sep_n)
                                                     - start_reg;
                        found_next                 = found_reg + COUNT_BITS'(1);
                    end
                end
            end
        end
        else
        begin
            // Close the last field (if one is open), report the summary, clear the record
            has_result = 1'b1;
            if ((sep_st.ws_mode && inside_reg) || !sep_st.ws_mode)
            begin
                if (pos_reg >= start_reg)
                    len = pos_reg - start_reg;
                if (room)
                begin
                    out_data_next.field_valid  = 1'b1;
                    out_data_next.field_number = found_reg[NUMBER_BITS-1:0];
                    out_data_next.field_start  = start_reg;
                    out_data_next.field_length = len;
                    found_next                 = found_reg + COUNT_BITS'(1);
                end
            end
            records_next                = records_reg + RECORD_BITS'(1);
            out_data_next.record_end    = 1'b1;
            out_data_next.record_fields = found_next;
            out_data_next.record_number = records_next;
            pos_next                    = '0;
            start_next                  = '0;
            inside_next                 = 1'b0;
            found_next                  = '0;
        end
    end

    always_comb
    begin
        if (accept && has_result)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_length_reg <= SEP_LEN_BITS'(1);
            sep_bytes_reg  <= SEP_BITS'(SPACE_CHAR);
            recent_reg     <= '0;
            pos_reg        <= '0;
            start_reg      <= '0;
            inside_reg     <= 1'b0;
            found_reg      <= '0;
            records_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_SEP_LENGTH: sep_length_reg <= cfg_data[SEP_LEN_BITS-1:0];
                    REG_SEP_BYTES:  sep_bytes_reg  <= cfg_data;
                    default:        ;
                endcase
            end
            if (accept)
            begin
                if (in_data.func == FUNC_END)
                    recent_reg <= '0;
                else if (pos_reg != POS_LIMIT)
                    recent_reg <= recent_next;
                pos_reg     <= pos_next;
                start_reg   <= start_next;
                inside_reg  <= inside_next;
                found_reg   <= found_next;
                records_reg <= records_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload carries no reset
    always_ff @(posedge clk)
    begin
        if (accept && has_result)
            out_data_reg <= out_data_next;
    end

    a_found_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= COUNT_BITS'(MAX_FIELDS))
        else $error("field count ran past its limit");

    a_start_behind_pos: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg <= pos_reg)
        else $error("open field starts past the current byte");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.func == FUNC_END |=> pos_reg == '0 && found_reg == '0
                                               && !inside_reg)
        else $error("record state not cleared at record end");

    a_data_result_is_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.record_end |-> out_data_reg.field_valid)
        else $error("data request produced a result with no field");

    a_end_bumps_records: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.func == FUNC_END |=>
            records_reg == $past(records_reg) + RECORD_BITS'(1))
        else $error("record number did not advance");

endmodule

`default_nettype wire

// ===== test/rfs_checker.sv =====
// Checker for the record field splitter: watches both channels and the register
// port, predicts each field and record report and compares it with what arrives.
// Depends on rfs_pkg.
`timescale 1ns / 1ps

module rfs_checker
    import rfs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  in_item_t            in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  out_item_t           out_data,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [SEP_BITS-1:0] cfg_data,
    output int                  error_count,
    output int                  results_due,
    output int                  records_checked,
    output int                  fields_checked
);

    logic [SEP_LEN_BITS-1:0]  sep_len;
    logic [SEP_BITS-1:0]      sep_text;
    logic [63:0]              window;
    logic [POSITION_BITS-1:0] pos;
    logic [POSITION_BITS-1:0] field_begin;
    logic                     in_field;
    int                       found;
    logic [RECORD_BITS-1:0]   records;
    out_item_t                reports_due[$];
    int                       errors;
    int                       records_done;
    int                       fields_done;

    function automatic int sep_used();
        return (sep_len > SEP_MAX_BYTES) ? SEP_MAX_BYTES : int'(sep_len);
    endfunction

    function automatic bit whitespace_split();
        return sep_used() == 0 || (sep_used() == 1 && sep_text[7:0] == SPACE_CHAR);
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == SPACE_CHAR || (c >= TAB_CHAR && c <= CR_CHAR);
    endfunction

    // Separator must end at offset last and not reach back before the open field
    function automatic bit separator_closes(int last, int n);
        if (last + 1 < int'(field_begin) + n)
            return 1'b0;
        for (int j = 0; j < n; j++)
            if (window[8*j +: 8] != sep_text[8*(n-1-j) +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic close_field(input int start, input int len, inout out_item_t r,
                               output bit made);
        made = 1'b0;
        if (found >= MAX_FIELDS)
            return;
        r.field_valid  = 1'b1;
        r.field_number = found[NUMBER_BITS-1:0];
        r.field_start  = start[POSITION_BITS-1:0];
        r.field_length = len[POSITION_BITS-1:0];
        found++;
        made = 1'b1;
    endtask

    task automatic predict_report(input in_item_t it, output bit has, output out_item_t r);
        int  p;
        int  n;
        int  len;
        bit  made;
        has = 1'b0;
        r   = '0;
        if (it.func == FUNC_DATA) begin
            // past the line limit the byte is dropped
            if (pos == {POSITION_BITS{1'b1}})
                return;
            window = {window[55:0], it.data_byte};
            p      = int'(pos);
            pos    = pos + POSITION_BITS'(1);
            if (whitespace_split()) begin
                if (is_blank(it.data_byte)) begin
                    if (in_field) begin
                        in_field = 1'b0;
                        close_field(int'(field_begin), p - int'(field_begin), r, has);
                    end
                end else if (!in_field) begin
                    in_field    = 1'b1;
                    field_begin = p[POSITION_BITS-1:0];
                end
            end else begin
                n = sep_used();
                if (separator_closes(p, n)) begin
                    close_field(int'(field_begin), p + 1 - n - int'(field_begin), r, has);
                    field_begin = POSITION_BITS'(p + 1);
                end
            end
        end else begin
            if (whitespace_split()) begin
                if (in_field)
                    close_field(int'(field_begin), int'(pos) - int'(field_begin), r, made);
            end else begin
                len = (pos >= field_begin) ? int'(pos) - int'(field_begin) : 0;
                close_field(int'(field_begin), len, r, made);
            end
            records         = records + RECORD_BITS'(1);
            has             = 1'b1;
            r.record_end    = 1'b1;
            r.record_fields = found[COUNT_BITS-1:0];
            r.record_number = records;
            window      = '0;
            pos         = '0;
            field_begin = '0;
            in_field    = 1'b0;
            found       = 0;
        end
    endtask

    task automatic compare_value(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        out_item_t report;
        bit        has;
        if (!rst_n)
        begin
            sep_len      = 4'd1;
            sep_text     = {56'd0, SPACE_CHAR};
            window       = '0;
            pos          = '0;
            field_begin  = '0;
            in_field     = 1'b0;
            found        = 0;
            records      = '0;
            errors       = 0;
            records_done = 0;
            fields_done  = 0;
            reports_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (reports_due.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, got %h",
                             $time, out_data);
                    errors++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    compare_value("field_valid", want.field_valid, out_data.field_valid);
                    compare_value("field_number", want.field_number, out_data.field_number);
                    compare_value("field_start", want.field_start, out_data.field_start);
                    compare_value("field_length", want.field_length, out_data.field_length);
                    compare_value("record_end", want.record_end, out_data.record_end);
                    compare_value("record_fields", want.record_fields,
                                  out_data.record_fields);
                    compare_value("record_number", want.record_number,
                                  out_data.record_number);
                    if (want.field_valid)
                        fields_done++;
                    if (want.record_end)
                        records_done++;
                end
            end
            // A request at this edge still sees the old register values
            if (in_valid && !in_stall)
            begin
                predict_report(in_data, has, report);
                if (has)
                    reports_due.push_back(report);
            end
            if (cfg_write)
            begin
                if (cfg_index == REG_SEP_LENGTH)
                    sep_len = cfg_data[SEP_LEN_BITS-1:0];
                else
                    sep_text = cfg_data;
            end
        end
        error_count     <= errors;
        results_due     <= reports_due.size();
        records_checked <= records_done;
        fields_checked  <= fields_done;
    end

endmodule

// ===== test/tb_record_field_splitter.sv =====
// Testbench top for record_field_splitter: resets the block, programs separator
// settings and feeds records of bytes; rfs_checker does all prediction and compare.
// Depends on rfs_pkg, record_field_splitter and rfs_checker.
`timescale 1ns / 1ps

module tb_record_field_splitter;
    import rfs_pkg::*;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    in_item_t            in_data   = '0;
    logic                out_stall = 1'b0;
    logic                cfg_write = 1'b0;
    logic                cfg_index = REG_SEP_LENGTH;
    logic [SEP_BITS-1:0] cfg_data  = '0;
    logic                in_stall;
    logic                out_valid;
    out_item_t           out_data;

    int          error_count;
    int          results_due;
    int          records_checked;
    int          fields_checked;

    int          items_sent     = 0;
    int          settings_used  = 0;
    int          sep_len_set    = 1;
    logic [63:0] sep_text_set   = {56'd0, SPACE_CHAR};
    bit          gaps_on        = 1'b1;
    bit          quiet          = 1'b0;
    int          holds_asked    = 0;
    int          holds_done     = 0;

    record_field_splitter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rfs_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .results_due     (results_due),
        .records_checked (records_checked),
        .fields_checked  (fields_checked)
    );

    always #10 clk = ~clk;

    initial
    begin
        #(20 * 600000);
        $display("record_field_splitter verification failed");
        $finish;
    end

    // Receiver: random stall bursts, one long hold on request, none at the end
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (holds_done != holds_asked)
            begin
                out_stall <= 1'b1;
                repeat (60) @(posedge clk);
                holds_done++;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    task automatic send_item(input logic func, input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= in_item_t'{func: func, data_byte: b};
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_item(FUNC_DATA, s[k]);
    endtask

    task automatic end_record();
        send_item(FUNC_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_separator();
        int n;
        n = (sep_len_set > SEP_MAX_BYTES) ? SEP_MAX_BYTES : sep_len_set;
        if (n == 0)
            send_item(FUNC_DATA, SPACE_CHAR);
        for (int k = 0; k < n; k++)
            send_item(FUNC_DATA, sep_text_set[8*k +: 8]);
    endtask

    task automatic send_content(input int pieces);
        int pick;
        for (int i = 0; i < pieces; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                send_separator();
            else if (pick == 3)
                send_item(FUNC_DATA, ($urandom_range(0, 5) == 0) ? SPACE_CHAR
                                     : 8'($urandom_range(TAB_CHAR, CR_CHAR)));
            else if (pick == 4)
                send_item(FUNC_DATA, 8'($urandom_range(0, 255)));
            else
                send_item(FUNC_DATA, 8'($urandom_range(8'h61, 8'h66)));
        end
    endtask

    // Hold off the sender until every outstanding report is back
    task automatic drain();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        for (int w = 0; w < 5000 && results_due != 0; w++)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_separator(input int len, input logic [63:0] text);
        cfg_write <= 1'b1;
        cfg_index <= REG_SEP_LENGTH;
        cfg_data  <= 64'(len);
        @(posedge clk);
        cfg_index <= REG_SEP_BYTES;
        cfg_data  <= text;
        @(posedge clk);
        cfg_write <= 1'b0;
        sep_len_set  = len;
        sep_text_set = text;
        settings_used++;
    endtask

    // Bytes that collide with record content so partial matches are common
    function automatic logic [63:0] random_separator();
        logic [63:0] text;
        for (int k = 0; k < 8; k++)
            case ($urandom_range(0, 3))
                0: text[8*k +: 8] = 8'h3A;
                1: text[8*k +: 8] = 8'h61;
                2: text[8*k +: 8] = 8'h00;
                default: text[8*k +: 8] = 8'($urandom_range(0, 255));
            endcase
        return text;
    endfunction

    initial
    begin
        int setting;
        int choice;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Whitespace mode after reset: leading, repeated and trailing blanks
        send_text(" ab  c\t");
        end_record();
        send_text("xy");
        end_record();
        end_record();
        drain();

        // Two-byte separator, matches must not overlap
        set_separator(2, 64'h3A3A);
        send_text("a:::b");
        end_record();
        drain();

        // Switch to whitespace mode in the middle of a record
        set_separator(1, 64'h2C);
        send_text("a,b");
        drain();
        set_separator(0, {64{1'b1}});
        send_text(" c");
        end_record();

        setting = 0;
        while (items_sent < 340)
        begin
            drain();
            choice = (setting < 10) ? setting : $urandom_range(0, 9);
            case (choice)
                0: set_separator(1, {$urandom(), 24'($urandom()), SPACE_CHAR});
                1: set_separator(0, {$urandom(), $urandom()});
                2: set_separator(1, 64'h2C);
                3: set_separator($urandom_range(2, 8), random_separator());
                4: set_separator(15, {64{1'b1}});
                5: set_separator(3, 64'd0);
                6: set_separator(1, {56'd0, TAB_CHAR});
                7: set_separator($urandom_range(9, 14), random_separator());
                8: set_separator(8, random_separator());
                default: set_separator(1, {$urandom(), $urandom()});
            endcase
            if (setting == 3)
                holds_asked++;
            // Overflow the field count with a run of separators
            if (setting == 2)
            begin
                for (int i = 0; i < 70; i++)
                    send_separator();
                end_record();
            end
            repeat ($urandom_range(1, 3))
            begin
                send_content($urandom_range(0, 12));
                end_record();
            end
            // Leave a record open across the next register change
            if ($urandom_range(0, 3) == 0)
                send_content($urandom_range(1, 6));
            setting++;
        end

        // Final stretch at full rate on both sides
        quiet   = 1'b1;
        gaps_on = 1'b0;
        drain();
        while (out_stall)
            @(posedge clk);
        set_separator($urandom_range(1, 4), random_separator());
        repeat (4)
        begin
            send_content($urandom_range(4, 12));
            end_record();
        end
        drain();

        $display("Checked %0d fields in %0d records from %0d requests under %0d separator settings",
                 fields_checked, records_checked, items_sent, settings_used);
        if (results_due != 0)
            $display("%0t ns: %0d expected reports never arrived", $time, results_due);
        if (error_count == 0 && results_due == 0)
            $display("record_field_splitter verification clean");
        else
            $display("record_field_splitter verification failed");
        $finish;
    end

endmodule

// ===== record_field_splitter.f =====
rtl/core/rfs_pkg.sv
rtl/core/rfs_sep_match.sv
rtl/core/record_field_splitter.sv
test/rfs_checker.sv
test/tb_record_field_splitter.sv
